/* sv/mmsba_pkg.sv */
// Package for the memory-map scan and bump allocator.
// Holds widths, reset constants, status codes and the map statistics record.
// Depends on nothing; every module of the block imports it.
package mmsba_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned PagesW = 52;
  localparam int unsigned PageShiftDefault = 12;
  localparam logic [WordW-1:0] IdentityLimitReset = 64'h0000_0001_0000_0000;

  localparam logic KindDescriptor = 1'b0;
  localparam logic KindRequest = 1'b1;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusMapFail = 2'd1,
    StatusRefused = 2'd2
  } status_e;

  typedef struct packed {
    logic [WordW-1:0] desc_count;
    logic [WordW-1:0] conv_count;
    logic [WordW-1:0] total_sum;
    logic [WordW-1:0] usable_sum;
    logic [WordW-1:0] reserved_sum;
    logic [WordW-1:0] best_base;
    logic [WordW-1:0] best_pages;
    logic [WordW-1:0] seed_base;
    logic [WordW-1:0] seed_pages;
  } stats_t;

endpackage

/* sv/mmsba_desc.sv */
// Descriptor scan: updates the map statistics for one descriptor.
// Also forms the parse check and the pool end for the seeded region.
// Depends on mmsba_pkg.
module mmsba_desc #(
  parameter int unsigned PageShift = mmsba_pkg::PageShiftDefault
) (
  input  mmsba_pkg::stats_t                 stats_i,
  input  logic                              first_i,
  input  logic                              conv_i,
  input  logic [mmsba_pkg::WordW-1:0]       base_i,
  input  logic [mmsba_pkg::PagesW-1:0]      pages_i,
  input  logic [mmsba_pkg::WordW-1:0]       limit_i,
  output mmsba_pkg::stats_t                 stats_o,
  output logic                              map_ok_o,
  output logic [mmsba_pkg::WordW-1:0]       pool_hi_o
);
  import mmsba_pkg::*;

  localparam logic [WordW-1:0] PageMask = (64'd1 << PageShift) - 64'd1;

  stats_t           cur;
  stats_t           nxt;
  logic [WordW-1:0] pages_w;
  logic [WordW-1:0] start;
  logic [WordW-1:0] end_al;
  logic [WordW-1:0] usable;
  logic [WordW-1:0] clip;
  logic [WordW-1:0] cand;

  always_comb begin
    cur = first_i ? '0 : stats_i;
    pages_w = {{(WordW-PagesW){1'b0}}, pages_i};
    start = (base_i + PageMask) & ~PageMask;
    end_al = (base_i + (pages_w << PageShift)) & ~PageMask;
    usable = (end_al > start) ? ((end_al - start) >> PageShift) : '0;
    clip = (end_al < limit_i) ? end_al : limit_i;
    cand = (clip > start) ? ((clip - start) >> PageShift) : '0;

    nxt = cur;
    nxt.desc_count = cur.desc_count + 64'd1;
    nxt.total_sum = cur.total_sum + pages_w;
    if (conv_i) begin
      nxt.conv_count = cur.conv_count + 64'd1;
      nxt.usable_sum = cur.usable_sum + usable;
      if (usable > cur.best_pages) begin
        nxt.best_pages = usable;
        nxt.best_base = start;
      end
      if (cand > cur.seed_pages) begin
        nxt.seed_pages = cand;
        nxt.seed_base = start;
      end
    end else begin
      nxt.reserved_sum = cur.reserved_sum + pages_w;
    end
  end

  assign stats_o = nxt;
  assign map_ok_o = (nxt.desc_count != '0) && (nxt.usable_sum != '0) &&
                    (nxt.seed_pages != '0);
  assign pool_hi_o = nxt.seed_base + (nxt.seed_pages << PageShift);

endmodule

/* sv/mmsba_alloc.sv */
// Bump allocation check: aligns the cursor and bounds-checks one request.
// Purely combinational; the top level holds the cursor.
// Depends on mmsba_pkg.
module mmsba_alloc (
  input  logic [mmsba_pkg::WordW-1:0] next_i,
  input  logic [mmsba_pkg::WordW-1:0] hi_i,
  input  logic [mmsba_pkg::WordW-1:0] bytes_i,
  input  logic [mmsba_pkg::WordW-1:0] align_i,
  output logic                        ok_o,
  output logic [mmsba_pkg::WordW-1:0] addr_o,
  output logic [mmsba_pkg::WordW-1:0] next_o
);
  import mmsba_pkg::*;

  logic [WordW-1:0] amask;
  logic [WordW-1:0] start;
  logic             pow2;
  logic             bad_req;
  logic             bad_fit;

  always_comb begin
    amask = align_i - 64'd1;
    pow2 = (align_i != '0) && ((align_i & amask) == '0);
    start = (next_i + amask) & ~amask;
    bad_req = (bytes_i == '0) || !pow2 || (next_i > hi_i);
    bad_fit = (start < next_i) || (start > hi_i) || (bytes_i > (hi_i - start));
    ok_o = !bad_req && !bad_fit;
    addr_o = ok_o ? start : '0;
    next_o = start + bytes_i;
  end

endmodule

/* sv/memory_map_scan_bump_allocator.sv */
// Top level of the memory-map scan and bump allocator.
// Holds the input stage, the map and pool state, and the result register.
// Depends on mmsba_pkg, mmsba_desc and mmsba_alloc.
//
// Items arrive on the slave stream: tuser carries the item kind and the
// first and conventional flags, tlast marks the last descriptor of a map,
// and tdata the region and request fields. Each item gives one result on
// the master stream: tuser carries the status, tdata the granted address
// followed by the map statistics and the pool pointers.
// An accepted item waits in the input stage, where the scan or allocation
// logic runs against the state registers; the result and the new state are
// registered together into the result register. The result is offered once
// the item has passed the input stage and the result register, and one
// item is taken every cycle while the receiver keeps tready high, as each
// item needs only a few adds and compares against the running registers.
// When the receiver stalls, the result is held and one more item may wait
// in the input stage; tready falls only when both stages are full.
// Reset empties both stages, clears all statistics and the pool, and sets
// the identity limit to 4 GiB. The limit is written through cfg_we_i and
// cfg_wdata_i; the user must write it only while the block is idle, as the block does not enforce this.
module memory_map_scan_bump_allocator #(
  parameter int unsigned PageShift = mmsba_pkg::PageShiftDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mmsba_pkg::WordW-1:0] cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // region_base, region_pages, request_bytes, request_alignment, zero pad.
  input  logic [247:0]                s_axis_tdata,
  // kind, first_descriptor, is_conventional.
  input  logic [2:0]                  s_axis_tuser,
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // granted_address, descriptor_count, conventional_count, total_page_sum,
  // usable_page_sum, reserved_page_sum, best_region_base, largest_pages,
  // pool_start, pool_cursor.
  output logic [639:0]                m_axis_tdata,
  // status.
  output logic [1:0]                  m_axis_tuser
);
  import mmsba_pkg::*;

  logic              in_valid_q;
  logic              kind_q, first_q, last_q, conv_q;
  logic [WordW-1:0]  base_q, bytes_q, align_q;
  logic [PagesW-1:0] pages_q;

  logic [WordW-1:0]  limit_q;
  stats_t            stats_q, stats_d;
  logic [WordW-1:0]  pool_lo_q, pool_lo_d;
  logic [WordW-1:0]  pool_next_q, pool_next_d;
  logic [WordW-1:0]  pool_hi_q, pool_hi_d;

  logic              out_valid_q;
  status_e           out_status_q, status_d;
  logic [639:0]      out_data_q;
  logic [WordW-1:0]  addr_d;

  stats_t            desc_stats;
  logic              map_ok;
  logic [WordW-1:0]  seed_hi;
  logic              grant_ok;
  logic [WordW-1:0]  grant_addr;
  logic [WordW-1:0]  grant_next;
  logic              advance;

  assign advance = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  mmsba_desc #(
    .PageShift(PageShift)
  ) u_desc (
    .stats_i  (stats_q),
    .first_i  (first_q),
    .conv_i   (conv_q),
    .base_i   (base_q),
    .pages_i  (pages_q),
    .limit_i  (limit_q),
    .stats_o  (desc_stats),
    .map_ok_o (map_ok),
    .pool_hi_o(seed_hi)
  );

  mmsba_alloc u_alloc (
    .next_i (pool_next_q),
    .hi_i   (pool_hi_q),
    .bytes_i(bytes_q),
    .align_i(align_q),
    .ok_o   (grant_ok),
    .addr_o (grant_addr),
    .next_o (grant_next)
  );

  always_comb begin
    stats_d = stats_q;
    pool_lo_d = pool_lo_q;
    pool_next_d = pool_next_q;
    pool_hi_d = pool_hi_q;
    status_d = StatusOk;
    addr_d = '0;
    if (kind_q == KindDescriptor) begin
      stats_d = desc_stats;
      if (last_q) begin
        if (map_ok) begin
          pool_lo_d = desc_stats.seed_base;
          pool_next_d = desc_stats.seed_base;
          pool_hi_d = seed_hi;
        end else begin
          status_d = StatusMapFail;
        end
      end
    end else begin
      addr_d = grant_addr;
      if (grant_ok) begin
        pool_next_d = grant_next;
      end else begin
        status_d = StatusRefused;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_status_q <= StatusOk;
      limit_q <= IdentityLimitReset;
      stats_q <= '0;
      pool_lo_q <= '0;
      pool_next_q <= '0;
      pool_hi_q <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        out_status_q <= status_d;
        stats_q <= stats_d;
        pool_lo_q <= pool_lo_d;
        pool_next_q <= pool_next_d;
        pool_hi_q <= pool_hi_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      kind_q <= s_axis_tuser[0];
      first_q <= s_axis_tuser[1];
      last_q <= s_axis_tlast;
      conv_q <= s_axis_tuser[2];
      base_q <= s_axis_tdata[63:0];
      pages_q <= s_axis_tdata[115:64];
      bytes_q <= s_axis_tdata[179:116];
      align_q <= s_axis_tdata[243:180];
    end
    if (advance) begin
      out_data_q <= {pool_next_d, pool_lo_d, stats_d.best_pages, stats_d.best_base,
                     stats_d.reserved_sum, stats_d.usable_sum, stats_d.total_sum,
                     stats_d.conv_count, stats_d.desc_count, addr_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_status_q;

  a_pool_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pool_lo_q <= pool_next_q) && (pool_next_q <= pool_hi_q))
    else $error("Pool cursor left the pool bounds.");

  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == StatusRefused)) |-> (m_axis_tdata[63:0] == '0))
    else $error("Refused request reported a nonzero address.");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q && !m_axis_tready))
    else $error("Input stalled while a stage was free.");

  a_fail_keeps_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (status_d == StatusMapFail)) |=>
      ($stable(pool_lo_q) && $stable(pool_next_q) && $stable(pool_hi_q)))
    else $error("Failed map parse changed the pool.");

endmodule

/* test/tb.sv */
// Self-checking testbench for memory_map_scan_bump_allocator.
// Drives descriptor and allocation transactions through a directed table and
// randomised phases, and checks every result against an in-bench map and pool model.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmsba_pkg::*;

  localparam int unsigned PgShift = PageShiftDefault;
  localparam logic [63:0] PgBytes = 64'd1 << PgShift;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned Patience = 4000;
  localparam int unsigned PhaseItems = 200;

  localparam logic [3:0] MaskReq = 4'(KindRequest);
  localparam logic [3:0] MaskFirst = 4'b0010;
  localparam logic [3:0] MaskLast = 4'b0100;
  localparam logic [3:0] MaskConv = 4'b1000;
  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] TopBit = 64'h8000_0000_0000_0000;
  localparam logic [51:0] MaxPages = 52'hF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [3:0]  user;
    logic [63:0] base;
    logic [51:0] pages;
    logic [63:0] bytes;
    logic [63:0] align;
  } item_t;

  typedef struct {
    status_e      st;
    logic [639:0] words;
  } outcome_t;

  typedef enum {RowItem, RowLimit} row_op_e;

  typedef struct {
    row_op_e     op;
    logic [3:0]  user;
    logic [63:0] base;
    logic [51:0] pages;
    logic [63:0] bytes;
    logic [63:0] align;
    bit          typed;
    status_e     st;
    logic [63:0] addr;
  } row_t;

  row_t plan [25] = '{
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'd64, 64'd8, 1'b1, StatusRefused, 64'h0},
    '{RowItem, MaskFirst | MaskLast, 64'h0, MaxPages, 64'h0, 64'h0,
      1'b1, StatusMapFail, 64'h0},
    '{RowItem, MaskFirst | MaskConv, 64'h1000, 52'd16, 64'h0, 64'h0, 1'b1, StatusOk, 64'h0},
    '{RowItem, MaskConv, 64'h1801, 52'd4, 64'h0, 64'h0, 1'b0, StatusOk, 64'h0},
    '{RowItem, 4'b0000, AllOnes, MaxPages, 64'h0, 64'h0, 1'b1, StatusOk, 64'h0},
    '{RowItem, MaskConv, 64'hFFFF_FFFF_FFFF_F001, 52'd3, 64'h0, 64'h0,
      1'b1, StatusOk, 64'h0},
    '{RowItem, MaskConv | MaskLast, 64'h10_0000, 52'd256, AllOnes, AllOnes,
      1'b1, StatusOk, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'd0, 64'd8, 1'b1, StatusRefused, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'd16, 64'd0, 1'b1, StatusRefused, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'd16, 64'd3, 1'b1, StatusRefused, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, AllOnes, 64'd1, 1'b1, StatusRefused, 64'h0},
    '{RowItem, MaskReq | MaskFirst | MaskLast | MaskConv, AllOnes, MaxPages, 64'd1, 64'd1,
      1'b0, StatusOk, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'd24, 64'd16, 1'b0, StatusOk, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'd1, TopBit, 1'b1, StatusRefused, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'hF_FFC0, 64'd64, 1'b0, StatusOk, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'd1, 64'd1, 1'b1, StatusRefused, 64'h0},
    '{RowLimit, 4'b0000, 64'h0, 52'h0, 64'h0, 64'h0, 1'b0, StatusOk, 64'h0},
    '{RowItem, MaskFirst | MaskConv | MaskLast, 64'h1000, 52'd8, 64'h0, 64'h0,
      1'b1, StatusMapFail, 64'h0},
    '{RowItem, MaskFirst | MaskConv | MaskLast, 64'h0, 52'd0, 64'h0, 64'h0,
      1'b1, StatusMapFail, 64'h0},
    '{RowLimit, 4'b0000, AllOnes, 52'h0, 64'h0, 64'h0, 1'b0, StatusOk, 64'h0},
    '{RowItem, MaskFirst | MaskConv | MaskLast, 64'hFFFF_FFFF_0000_0000, 52'hFFFF,
      64'h0, 64'h0, 1'b1, StatusOk, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'd16, TopBit, 1'b1, StatusRefused, 64'h0},
    '{RowItem, MaskReq, 64'h0, 52'h0, 64'd16, 64'd1, 1'b0, StatusOk, 64'h0},
    '{RowLimit, 4'b0000, IdentityLimitReset, 52'h0, 64'h0, 64'h0, 1'b0, StatusOk, 64'h0},
    '{RowItem, MaskFirst | MaskConv | MaskLast, 64'h2_0000_0000, 52'd16, 64'h0, 64'h0,
      1'b1, StatusMapFail, 64'h0}
  };

  string word_name [10] = '{"granted_address", "descriptor_count", "conventional_count",
    "total_page_sum", "usable_page_sum", "reserved_page_sum", "best_region_base",
    "largest_pages", "pool_start", "pool_cursor"};

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [63:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [247:0] s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [639:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  logic [63:0] id_limit;
  logic [63:0] n_desc, n_conv, pages_total, pages_usable, pages_reserved;
  logic [63:0] top_base, top_pages, cand_base, cand_pages;
  logic [63:0] heap_lo, heap_cursor, heap_end;

  outcome_t due_outcomes [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  bit hold_off_req;
  int send_streak;

  memory_map_scan_bump_allocator #(
    .PageShift(PgShift)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_pause(inout int streak);
    int r;
    if (streak > 0) begin
      streak--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      streak = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic outcome_t scan_or_grant(input item_t it);
    outcome_t o;
    logic [63:0] npg, lo, hi, gain, clip, reach, at, addr;
    o.st = StatusOk;
    addr = '0;
    npg = 64'(it.pages);
    if ((it.user & MaskReq) == '0) begin
      if (|(it.user & MaskFirst)) begin
        n_desc = '0; n_conv = '0; pages_total = '0; pages_usable = '0;
        pages_reserved = '0; top_base = '0; top_pages = '0;
        cand_base = '0; cand_pages = '0;
      end
      n_desc = n_desc + 1;
      pages_total = pages_total + npg;
      if (|(it.user & MaskConv)) begin
        lo = (it.base + PgBytes - 1) & ~(PgBytes - 1);
        hi = (it.base + (npg << PgShift)) & ~(PgBytes - 1);
        gain = (hi > lo) ? (hi - lo) >> PgShift : '0;
        n_conv = n_conv + 1;
        pages_usable = pages_usable + gain;
        if (gain > top_pages) begin
          top_pages = gain;
          top_base = lo;
        end
        clip = (hi < id_limit) ? hi : id_limit;
        reach = (clip > lo) ? (clip - lo) >> PgShift : '0;
        if (reach > cand_pages) begin
          cand_base = lo;
          cand_pages = reach;
        end
      end else begin
        pages_reserved = pages_reserved + npg;
      end
      if (|(it.user & MaskLast)) begin
        if (n_desc == '0 || pages_usable == '0 || cand_pages == '0) begin
          o.st = StatusMapFail;
        end else begin
          heap_lo = cand_base;
          heap_cursor = cand_base;
          heap_end = cand_base + (cand_pages << PgShift);
        end
      end
    end else begin
      if (it.bytes == '0 || it.align == '0 || (it.align & (it.align - 1)) != '0 ||
          heap_cursor > heap_end) begin
        o.st = StatusRefused;
      end else begin
        at = (heap_cursor + it.align - 1) & ~(it.align - 1);
        if (at < heap_cursor || at > heap_end || it.bytes > heap_end - at) begin
          o.st = StatusRefused;
        end else begin
          heap_cursor = at + it.bytes;
          addr = at;
        end
      end
    end
    o.words = {heap_cursor, heap_lo, top_pages, top_base, pages_reserved, pages_usable,
               pages_total, n_conv, n_desc, addr};
    return o;
  endfunction

  function automatic item_t map_entry(input bit first_desc, input bit last_desc);
    item_t it;
    it.user = 4'(KindDescriptor);
    if (first_desc) it.user |= MaskFirst;
    if (last_desc) it.user |= MaskLast;
    if ($urandom_range(0, 9) < 7) it.user |= MaskConv;
    it.base = 64'($urandom_range(0, 32'h3F_FFFF)) << PgShift;
    if ($urandom_range(0, 4) == 0) it.base |= 64'($urandom_range(1, (1 << PgShift) - 1));
    if ($urandom_range(0, 19) == 0) it.base = rand64();
    case ($urandom_range(0, 29))
      0: it.pages = 52'(rand64());
      1, 2, 3: it.pages = 52'($urandom);
      default: it.pages = 52'($urandom_range(0, 4096));
    endcase
    it.bytes = rand64();
    it.align = rand64();
    return it;
  endfunction

  function automatic item_t request_entry();
    item_t it;
    int r;
    it.user = {3'($urandom_range(0, 7)), KindRequest};
    it.base = rand64();
    it.pages = 52'(rand64());
    it.bytes = 64'($urandom_range(1, 8192));
    it.align = 64'd1 << $urandom_range(0, 12);
    r = $urandom_range(0, 99);
    if (r >= 97) it.bytes = rand64();
    else if (r >= 94) it.align = 64'd1 << $urandom_range(13, 63);
    else if (r >= 91) it.align = rand64() | 64'd3;
    else if (r >= 88) it.align = '0;
    else if (r >= 85) it.bytes = '0;
    return it;
  endfunction

  function automatic item_t noise_entry();
    item_t it;
    it.user = 4'($urandom);
    it.base = rand64();
    it.pages = 52'(rand64());
    it.bytes = rand64();
    it.align = rand64();
    return it;
  endfunction

  task automatic offer(input item_t it, input bit typed, input status_e st,
                       input logic [63:0] addr);
    int gap;
    outcome_t want;
    gap = pick_pause(send_streak);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'b0, it.align, it.bytes, it.pages, it.base};
    s_axis_tuser = {it.user[3], it.user[1:0]};
    s_axis_tlast = it.user[2];
    do @(posedge clk_i); while (!s_axis_tready);
    want = scan_or_grant(it);
    if (typed) begin
      want.st = st;
      want.words[63:0] = addr;
    end
    due_outcomes.push_back(want);
  endtask

  task automatic set_limit(input logic [63:0] value);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (due_outcomes.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    id_limit = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want_v,
                               input logic [63:0] got_v);
    if (mismatches < 10) begin
      $display("%0t: %s expected %h got %h", $realtime, what, want_v, got_v);
    end
    mismatches++;
  endtask

  initial begin
    item_t it;
    logic [63:0] lim;
    int n, m, sent;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    send_streak = 0;
    id_limit = IdentityLimitReset;
    n_desc = '0; n_conv = '0; pages_total = '0; pages_usable = '0; pages_reserved = '0;
    top_base = '0; top_pages = '0; cand_base = '0; cand_pages = '0;
    heap_lo = '0; heap_cursor = '0; heap_end = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].op == RowLimit) begin
        set_limit(plan[i].base);
      end else begin
        it = '{plan[i].user, plan[i].base, plan[i].pages, plan[i].bytes, plan[i].align};
        offer(it, plan[i].typed, plan[i].st, plan[i].addr);
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: lim = 64'h4000_0000;
        1: lim = AllOnes;
        2: lim = '0;
        3: lim = rand64();
        4: lim = {28'h0, 4'($urandom_range(0, 15)), 32'($urandom)};
        default: lim = IdentityLimitReset;
      endcase
      set_limit(lim);
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(0, 99) < 75) begin
          n = $urandom_range(1, 8);
          for (int i = 0; i < n; i++) begin
            offer(map_entry(i == 0 && $urandom_range(0, 9) != 0, i == n - 1),
                  1'b0, StatusOk, '0);
          end
          m = $urandom_range(0, 12);
          for (int i = 0; i < m; i++) offer(request_entry(), 1'b0, StatusOk, '0);
          sent += n + m;
        end else begin
          offer(noise_entry(), 1'b0, StatusOk, '0);
          sent++;
        end
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (due_outcomes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin
    int streak;
    int pause;
    streak = 0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      pause = pick_pause(streak);
      m_axis_tready = (pause == 0);
      repeat ((pause == 0) ? 1 : pause) @(negedge clk_i);
    end
  end

  // Results are checked in transaction order; the watchdog restarts on any transaction.
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (results_seen == 100 || results_seen == 800) hold_off_req = 1'b1;
        if (due_outcomes.size() == 0) begin
          flag_mismatch("unrequested result, status", '0, 64'(m_axis_tuser));
        end else begin
          want = due_outcomes.pop_front();
          if (m_axis_tuser !== want.st) begin
            flag_mismatch("status", 64'(want.st), 64'(m_axis_tuser));
          end
          for (int f = 0; f < 10; f++) begin
            if (m_axis_tdata[f*64 +: 64] !== want.words[f*64 +: 64]) begin
              flag_mismatch(word_name[f], want.words[f*64 +: 64], m_axis_tdata[f*64 +: 64]);
            end
          end
        end
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= Patience) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

endmodule

/* files.f */
sv/mmsba_pkg.sv
sv/mmsba_desc.sv
sv/mmsba_alloc.sv
sv/memory_map_scan_bump_allocator.sv
test/tb.sv
